FILE: src/fmcg_pkg.sv
// ----------------------------------------------------------------------------
// fmcg_pkg: shared types and constants of the clock governor
// Event, result and configuration payloads, event and register codes, the
// official rate tables and the governor ladder.
// ----------------------------------------------------------------------------
package fmcg_pkg;

    // Event kinds
    typedef enum logic [2:0] {
        KIND_FRAME     = 3'd0,
        KIND_TICK      = 3'd1,
        KIND_STALL     = 3'd2,
        KIND_LOAD_DONE = 3'd3,
        KIND_APPLY     = 3'd4
    } t_kind;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PLAY_CPU_MHZ    = 3'd0,
        CFG_BOOT_CPU_MHZ    = 3'd1,
        CFG_GPU_MHZ         = 3'd2,
        CFG_UP_MISSED_THR   = 3'd3,
        CFG_DOWN_CALM_SEC   = 3'd4,
        CFG_UP_CONFIRM_SEC  = 3'd5,
        CFG_MIN_FRAMES      = 3'd6
    } t_cfg_idx;

    localparam int LADDER_LEVELS_DEF = 5;
    localparam int CPU_TABLE_N       = 12;
    localparam int GPU_TABLE_N       = 7;
    localparam int LADDER_N          = 5;

    localparam logic [20:0] CPU_TABLE_KHZ [CPU_TABLE_N] = '{
        21'd612000,  21'd714000,  21'd816000,  21'd918000,
        21'd1020000, 21'd1122000, 21'd1224000, 21'd1326000,
        21'd1428000, 21'd1581000, 21'd1683000, 21'd1785000
    };
    localparam logic [19:0] GPU_TABLE_KHZ [GPU_TABLE_N] = '{
        20'd307200, 20'd384000, 20'd460800, 20'd537600,
        20'd614400, 20'd691200, 20'd768000
    };
    localparam logic [10:0] LADDER_MHZ [LADDER_N] = '{
        11'd1020, 11'd1224, 11'd1428, 11'd1581, 11'd1785
    };

    localparam logic [20:0] CPU_CAP_KHZ        = 21'd1785000;
    localparam logic [20:0] CPU_STOCK_KHZ      = 21'd1020000;
    localparam logic [19:0] GPU_CAP_DOCK_KHZ   = 20'd768000;
    localparam logic [19:0] GPU_CAP_HAND_KHZ   = 20'd460800;
    localparam logic [19:0] GPU_STOCK_DOCK_KHZ = 20'd768000;
    localparam logic [19:0] GPU_STOCK_HAND_KHZ = 20'd384000;

    // Register reset values
    localparam logic [11:0] PLAY_CPU_RST   = 12'hFFF;
    localparam logic [10:0] BOOT_CPU_RST   = 11'd1785;
    localparam logic [9:0]  GPU_MHZ_RST    = 10'd0;
    localparam logic [7:0]  UP_MISSED_RST  = 8'd3;
    localparam logic [3:0]  DOWN_CALM_RST  = 4'd10;
    localparam logic [1:0]  UP_CONFIRM_RST = 2'd2;
    localparam logic [7:0]  MIN_FRAMES_RST = 8'd20;

    // Payloads
    typedef struct packed {
        logic [2:0] kind;
        logic       vblank_miss;
        logic       focused;
        logic       docked;
        logic       stall_flag;
    } t_event;

    typedef struct packed {
        logic [20:0] cpu_want_khz;
        logic [19:0] gpu_want_khz;
        logic        apply_now;
        logic [2:0]  ladder_level;
    } t_result;

    typedef struct packed {
        logic [2:0]  index;
        logic [11:0] data;
    } t_cfg_req;

    // Context for rate selection
    typedef struct packed {
        logic        loading;
        logic        stalled;
        logic [2:0]  level;
        logic [11:0] play_cpu_mhz;
        logic [10:0] load_cpu_mhz;
        logic [9:0]  gpu_mhz;
        logic        docked;
    } t_pick_req;

    typedef struct packed {
        logic [20:0] cpu_khz;
        logic [19:0] gpu_khz;
    } t_pick_res;

endpackage

FILE: src/fmcg_chan_if.sv
// ----------------------------------------------------------------------------
// fmcg_chan_if: valid/ready channel
// Carries one request per accepted cycle; payload type set per instance.
// ----------------------------------------------------------------------------
interface fmcg_chan_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/fmcg_rate_pick.sv
// ----------------------------------------------------------------------------
// fmcg_rate_pick: official CPU and GPU rate selection
// Chooses the target MHz and maps it onto the largest official rate not
// above the request and the cap, or the lowest rate when none fits.
// ----------------------------------------------------------------------------
module fmcg_rate_pick (
    input  fmcg_pkg::t_pick_req i_req,
    output fmcg_pkg::t_pick_res o_res
);
    import fmcg_pkg::*;

    logic [10:0] s_cpu_mhz;
    logic [20:0] s_cpu_lim;
    logic [20:0] s_cpu_best;
    logic [19:0] s_gpu_lim;
    logic [19:0] s_gpu_cap;
    logic [19:0] s_gpu_best;

    // CPU request: boot rate while loading or stalled, else ladder or fixed
    always_comb begin
        if (i_req.loading || i_req.stalled) begin
            s_cpu_mhz = i_req.load_cpu_mhz;
        end else if (i_req.play_cpu_mhz[11]) begin
            s_cpu_mhz = (i_req.level < 3'(LADDER_N)) ? LADDER_MHZ[i_req.level]
                                                     : LADDER_MHZ[LADDER_N-1];
        end else begin
            s_cpu_mhz = i_req.play_cpu_mhz[10:0];
        end
    end

    assign s_cpu_lim = 21'(s_cpu_mhz) * 21'd1000;
    assign s_gpu_lim = 20'(i_req.gpu_mhz) * 20'd1000;
    assign s_gpu_cap = i_req.docked ? GPU_CAP_DOCK_KHZ : GPU_CAP_HAND_KHZ;

    // Table scans: last qualifying entry wins
    always_comb begin
        s_cpu_best = CPU_TABLE_KHZ[0];
        for (int i = 0; i < CPU_TABLE_N; i++) begin
            if (CPU_TABLE_KHZ[i] <= s_cpu_lim && CPU_TABLE_KHZ[i] <= CPU_CAP_KHZ) begin
                s_cpu_best = CPU_TABLE_KHZ[i];
            end
        end
    end

    always_comb begin
        s_gpu_best = GPU_TABLE_KHZ[0];
        for (int i = 0; i < GPU_TABLE_N; i++) begin
            if (GPU_TABLE_KHZ[i] <= s_gpu_lim && GPU_TABLE_KHZ[i] <= s_gpu_cap) begin
                s_gpu_best = GPU_TABLE_KHZ[i];
            end
        end
    end

    // Zero MHz means no preference
    assign o_res.cpu_khz = (s_cpu_mhz == 11'd0) ? 21'd0 : s_cpu_best;
    assign o_res.gpu_khz = (i_req.gpu_mhz == 10'd0) ? 20'd0 : s_gpu_best;

endmodule

FILE: src/frame_miss_cpu_clock_governor_unit.sv
// ----------------------------------------------------------------------------
// frame_miss_cpu_clock_governor_unit: frame-miss DVFS step governor
// Counts frames and missed vblanks per second, steps a CPU rate ladder with
// hysteresis on each focused tick and produces the requested rates in kHz.
// ----------------------------------------------------------------------------
// One event is taken every clock cycle while ready is high: the event lands
// in an input register, the governor, flag updates and rate selection settle
// in one pass of logic, and the outcome is held in a result register. Every
// event yields exactly one result; ready drops only while both registers are
// full and the result is not being taken.
// Configuration writes are always accepted and act on the next event.
module frame_miss_cpu_clock_governor_unit #(
    parameter int LADDER_LEVELS = fmcg_pkg::LADDER_LEVELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fmcg_chan_if.sink         i_evt,
    fmcg_chan_if.sink         i_cfg,
    fmcg_chan_if.source       o_res
);
    import fmcg_pkg::*;

    localparam logic [2:0] LEVEL_TOP = 3'(LADDER_LEVELS - 1);

    // Configuration registers
    logic [11:0] r_play_cpu;
    logic [10:0] r_boot_cpu;
    logic [9:0]  r_gpu_mhz;
    logic [7:0]  r_up_missed;
    logic [3:0]  r_down_calm;
    logic [1:0]  r_up_confirm;
    logic [7:0]  r_min_frames;

    // Governor state
    logic [2:0] r_level,   n_level;
    logic [3:0] r_calm,    n_calm;
    logic [1:0] r_hot,     n_hot;
    logic [1:0] r_slow,    n_slow;
    logic [7:0] r_frames,  n_frames;
    logic [7:0] r_missed,  n_missed;
    logic       r_loading, n_loading;
    logic       r_stalled, n_stalled;
    logic       r_cpu_tch, n_cpu_tch;
    logic       r_gpu_tch, n_gpu_tch;

    // Pipeline registers
    logic    r_in_valid;
    t_event  r_in;
    logic    r_out_valid;
    t_result r_out,     n_out;

    logic       s_adv;
    logic       s_apply;
    logic       s_focus;
    logic [1:0] s_slow_inc;
    logic [1:0] s_hot_inc;
    logic [3:0] s_calm_inc;
    logic [20:0] s_cpu;
    logic [19:0] s_gpu;
    t_pick_req  s_pick_req;
    t_pick_res  s_pick_res;

    // Handshakes
    assign s_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_evt.ready = !r_in_valid || s_adv;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_cpu   <= PLAY_CPU_RST;
            r_boot_cpu   <= BOOT_CPU_RST;
            r_gpu_mhz    <= GPU_MHZ_RST;
            r_up_missed  <= UP_MISSED_RST;
            r_down_calm  <= DOWN_CALM_RST;
            r_up_confirm <= UP_CONFIRM_RST;
            r_min_frames <= MIN_FRAMES_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_PLAY_CPU_MHZ:   r_play_cpu   <= i_cfg.data.data;
                CFG_BOOT_CPU_MHZ:   r_boot_cpu   <= i_cfg.data.data[10:0];
                CFG_GPU_MHZ:        r_gpu_mhz    <= i_cfg.data.data[9:0];
                CFG_UP_MISSED_THR:  r_up_missed  <= i_cfg.data.data[7:0];
                CFG_DOWN_CALM_SEC:  r_down_calm  <= i_cfg.data.data[3:0];
                CFG_UP_CONFIRM_SEC: r_up_confirm <= i_cfg.data.data[1:0];
                CFG_MIN_FRAMES:     r_min_frames <= i_cfg.data.data[7:0];
                default: ;
            endcase
        end
    end

    // Saturating counter increments
    assign s_slow_inc = (r_slow < 2'd3) ? 2'(r_slow + 2'd1) : r_slow;
    assign s_hot_inc  = (r_hot  < 2'd3) ? 2'(r_hot  + 2'd1) : r_hot;
    assign s_calm_inc = (r_calm < 4'd15) ? 4'(r_calm + 4'd1) : r_calm;

    // Event decode and governor step
    always_comb begin
        n_level   = r_level;
        n_calm    = r_calm;
        n_hot     = r_hot;
        n_slow    = r_slow;
        n_frames  = r_frames;
        n_missed  = r_missed;
        n_loading = r_loading;
        n_stalled = r_stalled;
        s_apply   = 1'b0;
        s_focus   = 1'b1;
        case (r_in.kind)
            KIND_FRAME: begin
                if (r_frames < 8'd255) n_frames = 8'(r_frames + 8'd1);
                if (r_in.vblank_miss && r_missed < 8'd255) begin
                    n_missed = 8'(r_missed + 8'd1);
                end
            end
            KIND_TICK: begin
                if (r_in.focused) begin
                    s_apply  = 1'b1;
                    n_frames = 8'd0;
                    n_missed = 8'd0;
                    if (!r_loading && r_play_cpu[11]) begin
                        if (r_frames < r_min_frames) begin
                            // slow second: jump to the top once confirmed
                            if (r_frames == 8'd0 || r_stalled) begin
                                n_slow = 2'd0;
                            end else begin
                                n_calm = 4'd0;
                                n_hot  = 2'd0;
                                if (s_slow_inc >= r_up_confirm && r_level < LEVEL_TOP) begin
                                    n_level = LEVEL_TOP;
                                    n_slow  = 2'd0;
                                end else begin
                                    n_slow = s_slow_inc;
                                end
                            end
                        end else begin
                            n_slow = 2'd0;
                            if (r_missed >= r_up_missed) begin
                                // bad second: step up once confirmed
                                n_calm = 4'd0;
                                if (s_hot_inc >= r_up_confirm && r_level < LEVEL_TOP) begin
                                    n_level = 3'(r_level + 3'd1);
                                    n_hot   = 2'd0;
                                end else begin
                                    n_hot = s_hot_inc;
                                end
                            end else if (r_missed == 8'd0) begin
                                // clean second: step down after the calm run
                                n_hot = 2'd0;
                                if (s_calm_inc >= r_down_calm && r_level > 3'd0) begin
                                    n_level = 3'(r_level - 3'd1);
                                    n_calm  = 4'd0;
                                end else begin
                                    n_calm = s_calm_inc;
                                end
                            end else begin
                                n_calm = 4'd0;
                                n_hot  = 2'd0;
                            end
                        end
                    end
                end
            end
            KIND_STALL: begin
                if (r_in.stall_flag != r_stalled) begin
                    n_stalled = r_in.stall_flag;
                    s_apply   = 1'b1;
                end
            end
            KIND_LOAD_DONE: begin
                n_loading = 1'b0;
            end
            KIND_APPLY: begin
                s_apply = 1'b1;
                s_focus = r_in.focused;
            end
            default: ;
        endcase
    end

    // Rate selection sees the state after this event
    assign s_pick_req.loading      = n_loading;
    assign s_pick_req.stalled      = n_stalled;
    assign s_pick_req.level        = n_level;
    assign s_pick_req.play_cpu_mhz = r_play_cpu;
    assign s_pick_req.load_cpu_mhz = r_boot_cpu;
    assign s_pick_req.gpu_mhz      = r_gpu_mhz;
    assign s_pick_req.docked       = r_in.docked;

    fmcg_rate_pick u_pick (
        .i_req (s_pick_req),
        .o_res (s_pick_res)
    );

    // Apply: fall back to stock once a clock has been touched
    always_comb begin
        n_cpu_tch = r_cpu_tch;
        n_gpu_tch = r_gpu_tch;
        s_cpu     = s_focus ? s_pick_res.cpu_khz : 21'd0;
        s_gpu     = s_focus ? s_pick_res.gpu_khz : 20'd0;
        if (s_cpu != 21'd0) begin
            n_cpu_tch = 1'b1;
        end else if (r_cpu_tch) begin
            s_cpu = CPU_STOCK_KHZ;
        end
        if (s_gpu != 20'd0) begin
            n_gpu_tch = 1'b1;
        end else if (r_gpu_tch) begin
            s_gpu = r_in.docked ? GPU_STOCK_DOCK_KHZ : GPU_STOCK_HAND_KHZ;
        end
        if (!s_apply) begin
            n_cpu_tch = r_cpu_tch;
            n_gpu_tch = r_gpu_tch;
            s_cpu     = 21'd0;
            s_gpu     = 20'd0;
        end
        n_out.cpu_want_khz = s_cpu;
        n_out.gpu_want_khz = s_gpu;
        n_out.apply_now    = s_apply;
        n_out.ladder_level = n_level;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.ready && i_evt.valid) begin
            r_in <= i_evt.data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_out <= n_out;
        end
    end

    // Governor state commits as the event moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= 3'd0;
            r_calm    <= 4'd0;
            r_hot     <= 2'd0;
            r_slow    <= 2'd0;
            r_frames  <= 8'd0;
            r_missed  <= 8'd0;
            r_loading <= 1'b1;
            r_stalled <= 1'b0;
            r_cpu_tch <= 1'b0;
            r_gpu_tch <= 1'b0;
        end else if (s_adv) begin
            r_level   <= n_level;
            r_calm    <= n_calm;
            r_hot     <= n_hot;
            r_slow    <= n_slow;
            r_frames  <= n_frames;
            r_missed  <= n_missed;
            r_loading <= n_loading;
            r_stalled <= n_stalled;
            r_cpu_tch <= n_cpu_tch;
            r_gpu_tch <= n_gpu_tch;
        end
    end

endmodule
